>>> hdl/pgbf_pkg.sv
// ----------------------------------------------------------------------------
// pgbf_pkg: shared types and constants of the paged Bloom filter
// Transaction payloads, operation codes, state encodings and the command
// that the front end hands to the back end.
// ----------------------------------------------------------------------------
package pgbf_pkg;

  localparam int unsigned HashW      = 128;
  localparam int unsigned SliceW     = 16;
  localparam int unsigned LevelW     = 4;
  localparam int unsigned PageCountW = 17;
  localparam int unsigned CfgDataW   = 17;
  localparam int unsigned CountW     = 32;
  localparam int unsigned AddrMaxW   = 20;
  localparam int unsigned ProbeW     = 3;
  localparam logic [LevelW-1:0] LevelMax = 4'd13;

  typedef enum logic [1:0] {
    FUNC_TEST  = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic {
    CFG_PAGE_LEVEL = 1'b0,
    CFG_PAGE_COUNT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] hash_low;
    logic [63:0] hash_high;
  } in_item_t;

  typedef struct packed {
    logic        result_flag;
    logic [31:0] unique_count;
  } out_item_t;

  typedef struct packed {
    func_e               func;
    logic [AddrMaxW-1:0] base;
    logic [SliceW-1:0]   mask;
    logic [HashW-1:0]    hash;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLR,
    B_IDLE,
    B_ADDR,
    B_RD,
    B_CHK,
    B_DONE
  } back_state_e;

endpackage

>>> hdl/pgbf_front.sv
// ----------------------------------------------------------------------------
// pgbf_front: front end of the paged Bloom filter
// Accepts transactions, folds the hash of a test or set into a page number
// with a bit-serial modulo by the page count and builds the back-end command.
// ----------------------------------------------------------------------------
module pgbf_front
  import pgbf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  input  logic [LevelW-1:0]     page_level_i,
  input  logic [PageCountW-1:0] page_count_i,
  output logic                  push_o,
  output cmd_t                  cmd_o,
  input  logic                  full_i
);

  front_state_e state_q, state_d;
  in_item_t item_q;
  logic [31:0] quo_q, quo_d;
  logic [PageCountW:0] rem_q, rem_d;
  logic [4:0] step_q, step_d;
  logic [PageCountW:0] trial;
  logic [PageCountW-1:0] divisor;
  logic [LevelW-1:0] level;
  logic [16:0] mask_w;
  logic [31:0] ph;
  logic [AddrMaxW+12:0] base_w;
  logic accept;

  assign accept = in_valid_i && (state_q == F_IDLE);

  assign ph = {in_data_i.hash_low[5:0], in_data_i.hash_low[31:6]}
            ^ {in_data_i.hash_low[35:32], in_data_i.hash_low[63:36]}
            ^ {in_data_i.hash_high[1:0], in_data_i.hash_high[31:2]}
            ^ in_data_i.hash_high[63:32];

  assign divisor = (page_count_i == '0) ? PageCountW'(1) : page_count_i;
  assign level   = (page_level_i > LevelMax) ? LevelMax : page_level_i;
  assign mask_w  = (17'd1 << ({1'b0, level} + 5'd3)) - 17'd1;
  assign trial   = {rem_q[PageCountW-1:0], quo_q[31]};
  assign base_w  = (AddrMaxW+13)'(rem_q[PageCountW-1:0]) << level;

  always_comb begin
    state_d = state_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    step_d  = step_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          quo_d  = ph;
          rem_d  = '0;
          step_d = '0;
          if (in_data_i.func == FUNC_TEST || in_data_i.func == FUNC_SET) begin
            state_d = F_DIV;
          end else begin
            state_d = F_PUSH;
          end
        end
      end
      F_DIV: begin
        quo_d  = {quo_q[30:0], 1'b0};
        rem_d  = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != F_IDLE);
    push_o       = (state_q == F_PUSH) && !full_i;
    cmd_o.func   = func_e'(item_q.func);
    cmd_o.base   = base_w[AddrMaxW-1:0];
    cmd_o.mask   = mask_w[SliceW-1:0];
    cmd_o.hash   = {item_q.hash_high, item_q.hash_low};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    step_q <= step_d;
  end

endmodule

>>> hdl/pgbf_queue.sv
// ----------------------------------------------------------------------------
// pgbf_queue: command queue between front and back end
// A two-entry queue of commands so each side can stall on its own.
// ----------------------------------------------------------------------------
module pgbf_queue
  import pgbf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/pgbf_back.sv
// ----------------------------------------------------------------------------
// pgbf_back: back end of the paged Bloom filter
// Owns the bit memory and the unique counter, runs one read per probe and a
// write-back on set, sweeps the memory on clear and after reset, holds the result.
// ----------------------------------------------------------------------------
module pgbf_back
  import pgbf_pkg::*;
#(
  parameter int unsigned HASHES    = 8,
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);

  back_state_e state_q, state_d;
  cmd_t cmd_q;
  logic [ProbeW-1:0] probe_q;
  logic all_set_q;
  logic boot_q;
  logic [AW-1:0] addr_q, clr_q;
  logic [2:0] bitsel_q;
  logic [7:0] mem [MEM_BYTES];
  logic [7:0] rdata_q;
  logic [CountW-1:0] count_q;
  logic out_valid_q;
  out_item_t out_q;
  logic [SliceW-1:0] idx;
  logic hit, last, load, clr_last;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0] mem_wdata;

  assign idx      = cmd_q.hash[{probe_q, 4'b0000} +: SliceW] & cmd_q.mask;
  assign hit      = rdata_q[bitsel_q];
  assign last     = (probe_q == ProbeW'(HASHES - 1));
  assign clr_last = (clr_q == AW'(MEM_BYTES - 1));
  assign load     = (state_q == B_DONE) && (!out_valid_q || !out_stall_i);
  assign pop_o    = (state_q == B_IDLE) && !empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLR: if (clr_last) state_d = boot_q ? B_IDLE : B_DONE;
      B_IDLE: begin
        if (!empty_i) begin
          case (head_i.func)
            FUNC_CLEAR: state_d = B_CLR;
            FUNC_TEST, FUNC_SET: state_d = B_ADDR;
            default: state_d = B_DONE;
          endcase
        end
      end
      B_ADDR: state_d = B_RD;
      B_RD: state_d = B_CHK;
      B_CHK: begin
        if ((cmd_q.func == FUNC_TEST && !hit) || last) begin
          state_d = B_DONE;
        end else begin
          state_d = B_ADDR;
        end
      end
      B_DONE: if (load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = rdata_q | (8'd1 << bitsel_q);
    case (state_q)
      B_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      B_CHK: mem_we = (cmd_q.func == FUNC_SET);
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      boot_q      <= 1'b1;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLR) begin
        clr_q <= clr_q + AW'(1);
        if (clr_last) begin
          boot_q  <= 1'b0;
          count_q <= '0;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
        if (cmd_q.func == FUNC_SET && !all_set_q && count_q != '1) begin
          count_q <= count_q + CountW'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q     <= head_i;
      probe_q   <= '0;
      all_set_q <= 1'b1;
    end
    if (state_q == B_ADDR) begin
      addr_q   <= cmd_q.base[AW-1:0] + AW'(idx >> 3);
      bitsel_q <= idx[2:0];
    end
    if (state_q == B_CHK) begin
      if (!hit) begin
        all_set_q <= 1'b0;
      end
      probe_q <= probe_q + ProbeW'(1);
    end
    if (load) begin
      case (cmd_q.func)
        FUNC_TEST: begin
          out_q.result_flag  <= all_set_q;
          out_q.unique_count <= count_q;
        end
        FUNC_SET: begin
          out_q.result_flag  <= !all_set_q;
          out_q.unique_count <= (!all_set_q && count_q != '1) ? count_q + CountW'(1)
                                                             : count_q;
        end
        default: begin
          out_q.result_flag  <= 1'b0;
          out_q.unique_count <= count_q;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/paged_bloom_filter_core.sv
// ----------------------------------------------------------------------------
// paged_bloom_filter_core: page-blocked Bloom filter
// Test, set and clear transactions on a byte-wide bit memory, with a
// saturating count of keys that added new bits.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  input    | in_valid_i / in_stall_o    | in_data_i  (func, hash)
//  output   | out_valid_o / out_stall_i  | out_data_o (flag, count)
//  config   | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// The front end finds the page of a test or set by a one-bit-per-cycle
// modulo by the page count; clear and unused codes skip the modulo.
// The back end steps through B_ADDR, B_RD and B_CHK for each probe, and a
// clear sweeps the memory one byte per cycle. After reset the same sweep
// runs before results flow. MEM_BYTES must be a power of two.
// A stalled output stops the back end, and the front when the queue is full.
// ----------------------------------------------------------------------------
module paged_bloom_filter_core
  import pgbf_pkg::*;
#(
  parameter int unsigned HASHES    = 8,
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [LevelW-1:0] page_level_q;
  logic [PageCountW-1:0] page_count_q;
  cmd_t push_cmd, head;
  q_status_t qs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_level_q <= LevelW'(6);
      page_count_q <= PageCountW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PAGE_LEVEL: page_level_q <= cfg_wdata_i[LevelW-1:0];
        CFG_PAGE_COUNT: page_count_q <= cfg_wdata_i[PageCountW-1:0];
        default: page_level_q <= page_level_q;
      endcase
    end
  end

  pgbf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .page_level_i (page_level_q),
    .page_count_i (page_count_q),
    .push_o       (qs.push),
    .cmd_o        (push_cmd),
    .full_i       (qs.full)
  );

  pgbf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (qs.push),
    .push_data_i (push_cmd),
    .pop_i       (qs.pop),
    .head_o      (head),
    .full_o      (qs.full),
    .empty_o     (qs.empty)
  );

  pgbf_back #(
    .HASHES    (HASHES),
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (qs.empty),
    .pop_o       (qs.pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(qs.push && qs.full))
    else $error("Command pushed into a full queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(qs.pop && qs.empty))
    else $error("Command popped from an empty queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   qs.push |=> !qs.empty)
    else $error("Queue empty right after a push.");

endmodule
